// File: rtl/assert_macros.svh
// assertion macros used by the timer core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

// File: rtl/ciat_pkg.sv
// shared types and constants of the interval timer
package ciat_pkg;

	localparam logic [2:0] MODE_TICK       = 3'd0;
	localparam logic [2:0] MODE_CTRL       = 3'd1;
	localparam logic [2:0] MODE_LATCH_LO   = 3'd2;
	localparam logic [2:0] MODE_LATCH_HI   = 3'd3;
	localparam logic [2:0] MODE_SET_TOGGLE = 3'd4;

	localparam logic [7:0]  TOGGLE_BITS = 8'h06;
	localparam logic [15:0] ALL_ONES16  = 16'hffff;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic       count_pulse;
	} item_t;

	typedef struct packed {
		logic [15:0] count_value;
		logic        underflow_pulse;
		logic        toggle_output;
	} result_t;

endpackage

// File: rtl/ciat_in_stage.sv
// input register stage of the interval timer
module ciat_in_stage import ciat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	assign item_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// File: rtl/ciat_timer_core.sv
// timer state, delay flags and per-item next-state logic
module ciat_timer_core import ciat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item_s1,
	output result_t res
);
	`include "assert_macros.svh"

	logic [15:0] counter_q, latch_q;
	logic        tog_en_q, toggle_q;
	logic        start_q, osr_q, floadr_q, phi2_q;
	logic        cnt2_q, cnt3_q, os0_q, load1_q, os_q, load_q;

	logic [15:0] counter_d, latch_d, dec;
	logic        tog_en_d, toggle_d, under;
	logic        start_d, osr_d, floadr_d, phi2_d;
	logic        cnt2_d, cnt3_d, os0_d, load1_d, os_d, load_d;

	always_comb begin
		counter_d = counter_q;
		latch_d   = latch_q;
		tog_en_d  = tog_en_q;
		toggle_d  = toggle_q;
		start_d   = start_q;
		osr_d     = osr_q;
		floadr_d  = floadr_q;
		phi2_d    = phi2_q;
		cnt2_d    = cnt2_q;
		cnt3_d    = cnt3_q;
		os0_d     = os0_q;
		load1_d   = load1_q;
		os_d      = os_q;
		load_d    = load_q;
		under     = 1'b0;
		dec       = counter_q;
		case (item_s1.mode)
			MODE_TICK: begin
				if (counter_q != 16'd0 && cnt3_q) begin
					dec = counter_q - 16'd1;
				end
				// delay chain advances one place
				cnt2_d   = start_q && phi2_q;
				cnt3_d   = cnt2_q || (item_s1.count_pulse && start_q);
				load1_d  = floadr_q;
				os0_d    = osr_q;
				load_d   = load1_q;
				os_d     = os0_q;
				floadr_d = 1'b0;
				counter_d = dec;
				if (dec == 16'd0 && cnt3_d) begin
					under  = 1'b1;
					load_d = 1'b1;
					if (os_d || os0_d) begin
						start_d = 1'b0;
						cnt2_d  = 1'b0;
					end
					toggle_d = tog_en_q ? !toggle_q : 1'b0;
				end
				if (load_d) begin
					counter_d = latch_q;
					cnt3_d    = 1'b0;
				end
			end
			MODE_CTRL: begin
				start_d  = item_s1.data_byte[0];
				osr_d    = item_s1.data_byte[3];
				floadr_d = item_s1.data_byte[4];
				phi2_d   = !item_s1.data_byte[5];
				tog_en_d = (item_s1.data_byte & TOGGLE_BITS) == TOGGLE_BITS;
			end
			MODE_LATCH_LO: begin
				latch_d = {latch_q[15:8], item_s1.data_byte};
				if (load_q) begin
					counter_d = {counter_q[15:8], item_s1.data_byte};
				end
			end
			MODE_LATCH_HI: begin
				latch_d = {item_s1.data_byte, latch_q[7:0]};
				if (load_q || !start_q) begin
					counter_d = {item_s1.data_byte, latch_q[7:0]};
				end
			end
			MODE_SET_TOGGLE: begin
				toggle_d = item_s1.data_byte[0];
			end
			default: begin
			end
		endcase
	end

	assign res.count_value     = counter_d;
	assign res.underflow_pulse = under;
	assign res.toggle_output   = toggle_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= ALL_ONES16;
			latch_q   <= ALL_ONES16;
			tog_en_q  <= 1'b0;
			toggle_q  <= 1'b0;
			start_q   <= 1'b0;
			osr_q     <= 1'b0;
			floadr_q  <= 1'b0;
			phi2_q    <= 1'b0;
			cnt2_q    <= 1'b0;
			cnt3_q    <= 1'b0;
			os0_q     <= 1'b0;
			load1_q   <= 1'b0;
			os_q      <= 1'b0;
			load_q    <= 1'b0;
		end else if (fire) begin
			counter_q <= counter_d;
			latch_q   <= latch_d;
			tog_en_q  <= tog_en_d;
			toggle_q  <= toggle_d;
			start_q   <= start_d;
			osr_q     <= osr_d;
			floadr_q  <= floadr_d;
			phi2_q    <= phi2_d;
			cnt2_q    <= cnt2_d;
			cnt3_q    <= cnt3_d;
			os0_q     <= os0_d;
			load1_q   <= load1_d;
			os_q      <= os_d;
			load_q    <= load_d;
		end
	end

	// a pending load always cancels the count stage
	`ASSERT_NEVER(a_load_cnt3, cnt3_q && load_q, "load and count stage 3 both set")
	// force load request lasts exactly until the next tick
	`ASSERT_PROP(a_floadr_clr, fire && item_s1.mode == MODE_TICK |=> !floadr_q, "force load stuck")
	// underflow reloads the counter from the latch
	`ASSERT_PROP(a_under_reload, fire && res.underflow_pulse |=> counter_q == latch_q, "no reload")
	`ASSERT_NEVER(a_under_tick, res.underflow_pulse && item_s1.mode != MODE_TICK, "stray underflow")

endmodule

// File: rtl/ciat_out_stage.sv
// result register of the interval timer
module ciat_out_stage import ciat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    free,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	assign free = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (free) begin
			result_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= res;
		end
	end

endmodule

// File: rtl/cia_interval_timer.sv
// top level of the 16-bit interval timer
//
//  channel  direction  payload   transfer when
//  item     in         item_t    item_valid & item_ready
//  result   out        result_t  result_valid & result_ready
//
// one result per item, passed from the input register to the result register after the item transfer
// one item per cycle sustained while results are taken: input register, state update, result register
// arst_n clears counter and latch to all ones, flags and toggle to zero
// a stalled result holds the result register; the input register still fills behind it
module cia_interval_timer import ciat_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_s1, free, adv;
	item_t   item_s1;
	result_t res;

	assign adv = valid_s1 && free;

	ciat_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.take       (adv),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	ciat_timer_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.item_s1 (item_s1),
		.res     (res)
	);

	ciat_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv),
		.res          (res),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: sim/tb_cia_interval_timer.sv
// self-checking testbench of the interval timer with a per-item predictor
module tb_cia_interval_timer import ciat_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_ITEMS = 1000;

	// pipeline flags at the chip's bit positions
	localparam logic [31:0] FLG_START    = 32'h0000_0001;
	localparam logic [31:0] FLG_STEP     = 32'h0000_0004;
	localparam logic [31:0] FLG_ONESHOTR = 32'h0000_0008;
	localparam logic [31:0] FLG_FLOADR   = 32'h0000_0010;
	localparam logic [31:0] FLG_PHI2     = 32'h0000_0020;
	localparam logic [31:0] FLG_CNT2     = 32'h0000_0100;
	localparam logic [31:0] FLG_CNT3     = 32'h0000_0200;
	localparam logic [31:0] FLG_ONESHOT0 = 32'h0000_0800;
	localparam logic [31:0] FLG_LOAD1    = 32'h0000_1000;
	localparam logic [31:0] FLG_ONESHOT  = 32'h0008_0000;
	localparam logic [31:0] FLG_LOAD     = 32'h0010_0000;
	localparam logic [31:0] FLG_OUT      = 32'h8000_0000;
	localparam logic [31:0] FLG_CTLMASK  = FLG_START | FLG_ONESHOTR | FLG_FLOADR | FLG_PHI2;

	// control byte bits used when building stimulus
	localparam logic [7:0] CTL_START   = 8'h01;
	localparam logic [7:0] CTL_ONESHOT = 8'h08;
	localparam logic [7:0] CTL_FLOAD   = 8'h10;
	localparam logic [7:0] CTL_CNTPIN  = 8'h20;
	localparam logic [2:0] MODE_UNUSED  = 3'd5;
	localparam logic [2:0] MODE_UNUSED2 = 3'd6;
	localparam logic [2:0] MODE_UNUSED3 = 3'd7;

	typedef struct {
		item_t it;
		bit    drain_first;
	} stim_entry_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	cia_interval_timer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// predictor state
	logic [15:0] tmr_count;
	logic [15:0] tmr_latch;
	logic [31:0] tmr_flags;
	logic [7:0]  tmr_ctrl;
	logic        tmr_toggle;

	stim_entry_t stim_q[$];
	result_t     predicted_results[$];

	int stim_items = 0;
	int offered_items = 0;
	int accepted_items = 0;
	int results_seen = 0;
	int underflows_seen = 0;
	int mismatch_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	logic [15:0] ready_pattern = 16'hffff;
	logic [5:0]  ready_phase = '0;
	int idle_cycles = 0;

	function automatic result_t predict_timer(item_t it);
		logic [31:0] f;
		logic [31:0] nf;
		logic        fired;
		result_t     r;
		fired = 1'b0;
		case (it.mode)
			MODE_TICK: begin
				f = tmr_flags;
				if (it.count_pulse)
					f |= FLG_STEP;
				if (tmr_count != 16'd0 && (f & FLG_CNT3) != 0)
					tmr_count = tmr_count - 16'd1;
				nf = f & (FLG_START | FLG_ONESHOTR | FLG_PHI2);
				if ((f & (FLG_START | FLG_PHI2)) == (FLG_START | FLG_PHI2))
					nf |= FLG_CNT2;
				if ((f & FLG_CNT2) != 0 || (f & (FLG_STEP | FLG_START)) == (FLG_STEP | FLG_START))
					nf |= FLG_CNT3;
				// request flags walk one stage down the delay chain
				nf |= (f & (FLG_FLOADR | FLG_ONESHOTR | FLG_LOAD1 | FLG_ONESHOT0)) << 8;
				f = nf;
				if (tmr_count == 16'd0 && (f & FLG_CNT3) != 0) begin
					f |= FLG_LOAD | FLG_OUT;
					if ((f & (FLG_ONESHOT | FLG_ONESHOT0)) != 0)
						f &= ~(FLG_START | FLG_CNT2);
					if ((tmr_ctrl & TOGGLE_BITS) == TOGGLE_BITS)
						tmr_toggle = ~tmr_toggle;
					else
						tmr_toggle = 1'b0;
					fired = 1'b1;
				end
				if ((f & FLG_LOAD) != 0) begin
					tmr_count = tmr_latch;
					f &= ~FLG_CNT3;
				end
				tmr_flags = f;
			end
			MODE_CTRL: begin
				tmr_flags &= ~FLG_CTLMASK;
				tmr_flags |= ({24'd0, it.data_byte} & FLG_CTLMASK) ^ FLG_PHI2;
				tmr_ctrl = it.data_byte;
			end
			MODE_LATCH_LO: begin
				tmr_latch[7:0] = it.data_byte;
				if ((tmr_flags & FLG_LOAD) != 0)
					tmr_count[7:0] = it.data_byte;
			end
			MODE_LATCH_HI: begin
				tmr_latch[15:8] = it.data_byte;
				if ((tmr_flags & FLG_LOAD) != 0 || (tmr_flags & FLG_START) == 0)
					tmr_count = tmr_latch;
			end
			MODE_SET_TOGGLE: begin
				tmr_toggle = it.data_byte[0];
			end
			default: begin
			end
		endcase
		if (fired)
			underflows_seen++;
		r.count_value = tmr_count;
		r.underflow_pulse = fired;
		r.toggle_output = tmr_toggle;
		return r;
	endfunction

	task automatic queue_item(logic [2:0] m, logic [7:0] d, logic p, bit drain = 1'b0);
		stim_entry_t e;
		e.it.mode = m;
		e.it.data_byte = d;
		e.it.count_pulse = p;
		e.drain_first = drain;
		stim_q.push_back(e);
		if (m <= MODE_SET_TOGGLE)
			stim_items++;
	endtask

	task automatic report(string what, int exp_val, int got_val);
		mismatch_count++;
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
	end

	// sender: bursts of transfers with random gaps
	always @(negedge clk) begin
		stim_entry_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && accepted_items < offered_items) begin
			// offered item still waiting for its transfer
		end else if (burst_left == 0) begin
			item_valid <= 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else if (stim_q.size() == 0) begin
			item_valid <= 1'b0;
		end else if (stim_q[0].drain_first &&
				(accepted_items < offered_items || predicted_results.size() != 0)) begin
			item_valid <= 1'b0;
		end else begin
			nxt = stim_q.pop_front();
			item <= nxt.it;
			item_valid <= 1'b1;
			offered_items++;
			burst_left--;
		end
	end

	// receiver: rotating stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else if (!long_hold_done && accepted_items >= 400) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			result_ready <= 1'b0;
		end else begin
			if (ready_phase == 6'd0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hffff;
					1: ready_pattern = 16'($urandom) | 16'h0001;
					2: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
					default: ready_pattern = ~16'($urandom & $urandom) | 16'h0001;
				endcase
			end
			result_ready <= ready_pattern[ready_phase[3:0]];
			ready_phase = ready_phase + 6'd1;
		end
	end

	// monitor: predict on input transfer, check on result transfer
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					report("unexpected result count_value", 0, int'(result.count_value));
				end else begin
					want = predicted_results.pop_front();
					if (result.count_value !== want.count_value)
						report("count_value", int'(want.count_value),
							int'(result.count_value));
					if (result.underflow_pulse !== want.underflow_pulse)
						report("underflow_pulse", int'(want.underflow_pulse),
							int'(result.underflow_pulse));
					if (result.toggle_output !== want.toggle_output)
						report("toggle_output", int'(want.toggle_output),
							int'(result.toggle_output));
				end
			end
			if (item_valid && item_ready) begin
				predicted_results.push_back(predict_timer(item));
				accepted_items++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] ctl;
		int n;
		tmr_count = ALL_ONES16;
		tmr_latch = ALL_ONES16;
		tmr_flags = '0;
		tmr_ctrl = '0;
		tmr_toggle = 1'b0;

		// undefined mode right after reset reports the reset values
		queue_item(MODE_UNUSED, 8'hff, 1'b1);
		queue_item(MODE_TICK, 8'h00, 1'b1);
		queue_item(MODE_LATCH_LO, 8'h03, 1'b0);
		queue_item(MODE_LATCH_HI, 8'h00, 1'b0);
		queue_item(MODE_CTRL, CTL_START | CTL_FLOAD, 1'b0);
		for (int i = 0; i < 6; i++)
			queue_item(MODE_TICK, 8'h00, i[0]);
		queue_item(MODE_SET_TOGGLE, 8'h01, 1'b0);
		queue_item(MODE_CTRL, CTL_START | TOGGLE_BITS, 1'b0);
		for (int i = 0; i < 5; i++)
			queue_item(MODE_TICK, 8'hff, 1'b0);
		queue_item(MODE_LATCH_LO, 8'hff, 1'b0);
		queue_item(MODE_LATCH_HI, 8'hff, 1'b0);
		queue_item(MODE_CTRL, CTL_START | CTL_ONESHOT | CTL_FLOAD | CTL_CNTPIN, 1'b0);
		queue_item(MODE_TICK, 8'h00, 1'b1);
		queue_item(MODE_TICK, 8'h00, 1'b1);
		queue_item(MODE_UNUSED2, 8'h00, 1'b0);
		queue_item(MODE_UNUSED3, 8'h5a, 1'b1);
		queue_item(MODE_SET_TOGGLE, 8'hfe, 1'b1);
		// sender waits here until every expected result has come
		queue_item(MODE_CTRL, 8'h00, 1'b0, 1'b1);

		// mostly programmed runs with random content, some raw noise
		while (stim_items < 22 + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				// first write of a run waits for an empty pipeline now and then
				if ($urandom_range(0, 1) == 0) begin
					queue_item(MODE_LATCH_LO, 8'(($urandom_range(0, 3) == 0) ? $urandom :
						$urandom_range(0, 12)), 1'b0, $urandom_range(0, 25) == 0);
					queue_item(MODE_LATCH_HI,
						8'(($urandom_range(0, 4) == 0) ? $urandom : 32'd0), 1'($urandom));
				end else begin
					queue_item(MODE_LATCH_HI,
						8'(($urandom_range(0, 4) == 0) ? $urandom : 32'd0), 1'($urandom),
						$urandom_range(0, 25) == 0);
					queue_item(MODE_LATCH_LO, 8'(($urandom_range(0, 3) == 0) ? $urandom :
						$urandom_range(0, 12)), 1'b0);
				end
				ctl = 8'($urandom);
				if ($urandom_range(0, 4) != 0)
					ctl |= CTL_START;
				if ($urandom_range(0, 3) != 0)
					ctl &= ~CTL_CNTPIN;
				if ($urandom_range(0, 2) == 0)
					ctl |= TOGGLE_BITS;
				queue_item(MODE_CTRL, ctl, 1'($urandom));
				if ($urandom_range(0, 4) == 0)
					queue_item(MODE_SET_TOGGLE, 8'($urandom), 1'($urandom));
				n = $urandom_range(4, 40);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 39))
						0: queue_item(MODE_LATCH_LO, 8'($urandom), 1'($urandom));
						1: queue_item(MODE_LATCH_HI, 8'($urandom_range(0, 1)), 1'($urandom));
						2: queue_item(MODE_CTRL, 8'($urandom), 1'($urandom));
						default: queue_item(MODE_TICK, 8'($urandom), 1'($urandom));
					endcase
				end
			end else begin
				queue_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
			end
		end

		@(posedge arst_n);
		while (stim_q.size() != 0 || accepted_items != offered_items ||
				predicted_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d items (%0d queued), %0d results checked, %0d underflows",
			accepted_items, stim_items, results_seen, underflows_seen);
		$display("long result hold-off of %0d cycles applied: %0d, mismatches: %0d",
			LONG_HOLD, long_hold_done, mismatch_count);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/ciat_pkg.sv
rtl/ciat_in_stage.sv
rtl/ciat_timer_core.sv
rtl/ciat_out_stage.sv
rtl/cia_interval_timer.sv
sim/tb_cia_interval_timer.sv
